// ===== rtl/ipc_pkg.sv =====
// Package for the IPv4 protocol counter: shared types, field widths and codes.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package ipc_pkg;

    // Field widths of the stream items and the configuration register.
    localparam int LINK_LEN_W = 7;
    localparam int BYTE_W     = 8;
    localparam int CLASS_W    = 3;
    localparam int TOTAL_W    = 32;
    localparam int NUM_COUNTS = 5;
    localparam int TDATA_OUT_W = ((CLASS_W + NUM_COUNTS * TOTAL_W + 7) / 8) * 8;

    localparam logic [LINK_LEN_W-1:0] LINK_LEN_RESET = LINK_LEN_W'(14);

    // Input command codes carried on the slave tuser.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kind codes carried on the master tuser.
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Frame classes; the class code doubles as the counter index for all but CLS_DROP.
    localparam logic [CLASS_W-1:0] CLS_TCP   = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_UDP   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_ICMP  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_OTHER = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_DROP  = 3'd4;
    localparam int CNT_ALL = 4;

    // Depth of the event queue between parser and counter engine.
    localparam int QUEUE_DEPTH = 4;

    // One event from the parser: a classified frame or a statistics tick.
    typedef struct packed {
        logic               is_tick;
        logic [CLASS_W-1:0] pkt_class;
    } t_event;

endpackage

// ===== rtl/ipc_frame_parser.sv =====
// Front end of the IPv4 protocol counter: takes frame bytes, captures header
// fields and classifies each frame at its last byte. Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ipc_pkg::LINK_LEN_W-1:0] i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [ipc_pkg::BYTE_W-1:0]     i_byte,
    input  logic                           i_last,
    output logic                           o_push,
    output ipc_pkg::t_event                o_event,
    input  logic                           i_full
);
    import ipc_pkg::*;

    localparam int SEEN_VIHL  = 0;
    localparam int SEEN_PROTO = 1;
    localparam int SEEN_TCP   = 2;

    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [5:0] HDR_MIN      = 6'd20;
    localparam logic [5:0] HDR_MAX      = 6'd60;
    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] POS_MAX      = 8'd255;

    logic [LINK_LEN_W-1:0] r_link_len;
    logic [7:0]            r_pos;
    logic [3:0]            r_version;
    logic [3:0]            r_ihl;
    logic [7:0]            r_proto;
    logic [3:0]            r_tcp_off;
    logic [2:0]            r_seen;

    // Header fields with the current byte merged in.
    logic [7:0] m_pos;
    logic [3:0] m_version;
    logic [3:0] m_ihl;
    logic [7:0] m_proto;
    logic [3:0] m_tcp_off;
    logic [2:0] m_seen;

    logic [8:0] ip_start;
    logic [8:0] tcp_pos;
    logic [8:0] pos_ext;
    logic       accept;
    logic       byte_take;
    logic [5:0] ip_len;
    logic [5:0] tcp_len;
    logic [CLASS_W-1:0] frame_class;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign byte_take = accept && (i_cmd == CMD_BYTE);

    // Positions of the fields of interest within the frame.
    assign ip_start = {2'b00, r_link_len};
    assign tcp_pos  = ip_start + {3'b000, r_ihl, 2'b00} + 9'd12;
    assign pos_ext  = {1'b0, r_pos};

    always_comb begin
        m_pos     = (r_pos != POS_MAX) ? r_pos + 8'd1 : r_pos;
        m_version = r_version;
        m_ihl     = r_ihl;
        m_proto   = r_proto;
        m_tcp_off = r_tcp_off;
        m_seen    = r_seen;
        if (pos_ext == ip_start) begin
            m_version = i_byte[7:4];
            m_ihl     = i_byte[3:0];
            m_seen[SEEN_VIHL] = 1'b1;
        end
        if (pos_ext == ip_start + 9'd9) begin
            m_proto = i_byte;
            m_seen[SEEN_PROTO] = 1'b1;
        end
        if (r_seen[SEEN_VIHL] && pos_ext == tcp_pos) begin
            m_tcp_off = i_byte[7:4];
            m_seen[SEEN_TCP] = 1'b1;
        end
    end

    // Classification of a frame that ends with the current byte.
    assign ip_len  = {m_ihl, 2'b00};
    assign tcp_len = {m_tcp_off, 2'b00};

    always_comb begin
        if (!m_seen[SEEN_VIHL] || ip_len < HDR_MIN || ip_len > HDR_MAX
                || m_version != IPV4_VERSION || !m_seen[SEEN_PROTO]) begin
            frame_class = CLS_DROP;
        end else if (m_proto == PROTO_TCP) begin
            if (!m_seen[SEEN_TCP] || tcp_len < HDR_MIN || tcp_len > HDR_MAX) begin
                frame_class = CLS_DROP;
            end else begin
                frame_class = CLS_TCP;
            end
        end else if (m_proto == PROTO_UDP) begin
            frame_class = CLS_UDP;
        end else if (m_proto == PROTO_ICMP) begin
            frame_class = CLS_ICMP;
        end else begin
            frame_class = CLS_OTHER;
        end
    end

    // A tick or the last byte of a frame produces one event.
    assign o_push            = accept && (i_cmd == CMD_TICK || i_last);
    assign o_event.is_tick   = (i_cmd == CMD_TICK);
    assign o_event.pkt_class = frame_class;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_len <= LINK_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_link_len <= i_cfg_wr_data;
        end
    end

    // Frame state: advances on each byte and clears after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_version <= '0;
            r_ihl     <= '0;
            r_proto   <= '0;
            r_tcp_off <= '0;
            r_seen    <= '0;
        end else if (byte_take) begin
            if (i_last) begin
                r_pos     <= '0;
                r_version <= '0;
                r_ihl     <= '0;
                r_proto   <= '0;
                r_tcp_off <= '0;
                r_seen    <= '0;
            end else begin
                r_pos     <= m_pos;
                r_version <= m_version;
                r_ihl     <= m_ihl;
                r_proto   <= m_proto;
                r_tcp_off <= m_tcp_off;
                r_seen    <= m_seen;
            end
        end
    end

    // The TCP offset is only located once the IP header length is known.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen[SEEN_TCP] |-> r_seen[SEEN_VIHL])
        else $error("TCP offset captured without IP header byte");

endmodule

// ===== rtl/ipc_event_queue.sv =====
// Short queue of parser events between the front end and the counter engine.
// Depends on ipc_pkg for the event type and the depth.
`timescale 1ns / 1ps

module ipc_event_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ipc_pkg::t_event i_event,
    output logic            o_full,
    input  logic            i_pop,
    output ipc_pkg::t_event o_event,
    output logic            o_valid
);
    import ipc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_event           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("Event queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("Event queue overflow or underflow");

endmodule

// ===== rtl/ipc_count_engine.sv =====
// Back end of the IPv4 protocol counter: saturating class counters, report
// and clear on a tick, and the registered result stage. Depends on ipc_pkg.
`timescale 1ns / 1ps

module ipc_count_engine #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ev_valid,
    input  ipc_pkg::t_event             i_event,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_kind,
    output logic [ipc_pkg::CLASS_W-1:0] o_pkt_class,
    output logic [ipc_pkg::TOTAL_W-1:0] o_totals [ipc_pkg::NUM_COUNTS]
);
    import ipc_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_COUNTS];
    logic [TOTAL_W-1:0]     cnt_low [NUM_COUNTS];
    logic [63:0]            cnt_ext [NUM_COUNTS];

    logic               r_out_valid;
    logic               r_kind;
    logic [CLASS_W-1:0] r_class;
    logic [TOTAL_W-1:0] r_tot [NUM_COUNTS];

    // Take the next event when the result register is free or being drained.
    assign o_pop = i_ev_valid && (!r_out_valid || i_ready);

    // Reported value is the low part of each counter.
    always_comb begin
        for (int j = 0; j < NUM_COUNTS; j++) begin
            cnt_ext[j] = 64'(r_cnt[j]);
            cnt_low[j] = cnt_ext[j][TOTAL_W-1:0];
        end
    end

    // Counters: a tick clears them, a frame bumps the total and, unless dropped, its class.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_COUNTS; j++) begin
                r_cnt[j] <= '0;
            end
        end else if (o_pop) begin
            for (int j = 0; j < NUM_COUNTS; j++) begin
                if (i_event.is_tick) begin
                    r_cnt[j] <= '0;
                end else if ((j == CNT_ALL
                              || (i_event.pkt_class == CLASS_W'(j)
                                  && i_event.pkt_class != CLS_DROP))
                             && r_cnt[j] != '1) begin
                    r_cnt[j] <= r_cnt[j] + 1'b1;
                end
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_event.is_tick) begin
                r_kind  <= KIND_REPORT;
                r_class <= '0;
                for (int j = 0; j < NUM_COUNTS; j++) begin
                    r_tot[j] <= cnt_low[j];
                end
            end else begin
                r_kind  <= KIND_FRAME;
                r_class <= i_event.pkt_class;
                for (int j = 0; j < NUM_COUNTS; j++) begin
                    r_tot[j] <= '0;
                end
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_pkt_class = r_class;
    assign o_totals    = r_tot;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_event.is_tick) |=> (r_cnt[CNT_ALL] == '0))
        else $error("Counters not cleared after a report");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_FRAME) |-> (r_tot[CNT_ALL] == '0))
        else $error("Frame result carries counter values");

endmodule

// ===== rtl/ipv4_protocol_counter_unit.sv =====
// Result path: the transfer that causes a result writes its queue entry, the back end later pops it into
// the result register, and it is then valid on the master side; a master stall holds the pop back.
// Throughput: one input transfer per cycle while the queue is not full; one result per cycle while
// the master side is ready, set by the single counter update and result register in the back end.
// Reset (synchronous, active low): counters zero, link header length 14,
// queue and result stage empty, any partial frame discarded.
`timescale 1ns / 1ps

module ipv4_protocol_counter_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ipc_pkg::LINK_LEN_W-1:0]     i_cfg_wr_data,  // link_header_len
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ipc_pkg::BYTE_W-1:0]         s_axis_tdata,   // frame_byte
    input  logic                               s_axis_tlast,   // last_byte
    input  logic                               s_axis_tuser,   // cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pkt_class, tcp_total, udp_total, icmp_total, other_total, all_total, zero pad
    output logic [ipc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser    // kind
);
    import ipc_pkg::*;

    localparam int PAD_W = TDATA_OUT_W - CLASS_W - NUM_COUNTS * TOTAL_W;

    logic               push;
    logic               full;
    logic               pop;
    logic               ev_valid;
    t_event             push_event;
    t_event             head_event;
    logic [CLASS_W-1:0] out_class;
    logic [TOTAL_W-1:0] out_totals [NUM_COUNTS];

    // Front end: byte parsing and frame classification.
    ipc_frame_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_event       (push_event),
        .i_full        (full)
    );

    // Decoupling queue.
    ipc_event_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .o_full  (full),
        .i_pop   (pop),
        .o_event (head_event),
        .o_valid (ev_valid)
    );

    // Back end: counters and result stage.
    ipc_count_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counts (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (ev_valid),
        .i_event     (head_event),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_pkt_class (out_class),
        .o_totals    (out_totals)
    );

    // Result packing, first field in the lowest bits.
    assign m_axis_tdata = {PAD_W'(0), out_totals[4], out_totals[3], out_totals[2],
                           out_totals[1], out_totals[0], out_class};

endmodule

// ===== tb/ipv4_protocol_counter_unit_tb.sv =====
// Self-checking bench for the IPv4 protocol counter: streams frames and ticks,
// tracks protocol classes and saturating counts, and checks every result.
// Depends on ipc_pkg and ipv4_protocol_counter_unit.
`timescale 1ns / 1ps

module ipv4_protocol_counter_unit_tb;

    import ipc_pkg::*;

    localparam int COUNT_WIDTH  = 32;
    localparam int HDR_MIN      = 20;
    localparam int HDR_MAX      = 60;
    localparam int IP_VERSION_4 = 4;
    localparam int PROTO_ICMP   = 1;
    localparam int PROTO_TCP    = 6;
    localparam int PROTO_UDP    = 17;
    localparam int SEEN_VIHL    = 1;
    localparam int SEEN_PROTO   = 2;
    localparam int SEEN_TCPOFF  = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int TICK_PCT     = 3;

    // One awaited result: classification or statistics report.
    typedef struct packed {
        bit                              kind;
        bit [CLASS_W-1:0]                cls;
        bit [NUM_COUNTS-1:0][TOTAL_W-1:0] totals;
    } t_owed;

    // Tracks frame parsing and class counts, and holds the results still owed.
    class ipv4_tally;
        localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_WIDTH);

        int unsigned      link_len = LINK_LEN_RESET;
        int unsigned      byte_pos;
        int unsigned      version;
        int unsigned      ihl_words;
        int unsigned      proto;
        int unsigned      tcp_words;
        int unsigned      seen;
        longint unsigned  counts [NUM_COUNTS];
        t_owed            owed [$];
        int unsigned      faults;

        function void clear_frame();
            byte_pos  = 0;
            version   = 0;
            ihl_words = 0;
            proto     = 0;
            tcp_words = 0;
            seen      = 0;
        endfunction

        function void bump(int idx);
            if (counts[idx] < COUNT_MAX) counts[idx]++;
        endfunction

        // Latch the header fields that fall on the current byte position.
        function void capture(bit [BYTE_W-1:0] b);
            if (byte_pos == link_len) begin
                version   = b[7:4];
                ihl_words = b[3:0];
                seen      = seen | SEEN_VIHL;
            end
            if (byte_pos == link_len + 9) begin
                proto = b;
                seen  = seen | SEEN_PROTO;
            end
            if ((seen & SEEN_VIHL) != 0 && byte_pos == link_len + ihl_words * 4 + 12) begin
                tcp_words = b[7:4];
                seen      = seen | SEEN_TCPOFF;
            end
            if (byte_pos < 255) byte_pos++;
        endfunction

        function bit [CLASS_W-1:0] classify();
            if ((seen & SEEN_VIHL) == 0) return CLS_DROP;
            if (ihl_words * 4 < HDR_MIN || ihl_words * 4 > HDR_MAX || version != IP_VERSION_4)
                return CLS_DROP;
            if ((seen & SEEN_PROTO) == 0) return CLS_DROP;
            if (proto == PROTO_TCP) begin
                if ((seen & SEEN_TCPOFF) == 0) return CLS_DROP;
                if (tcp_words * 4 < HDR_MIN || tcp_words * 4 > HDR_MAX) return CLS_DROP;
                return CLS_TCP;
            end
            if (proto == PROTO_UDP) return CLS_UDP;
            if (proto == PROTO_ICMP) return CLS_ICMP;
            return CLS_OTHER;
        endfunction

        // Account for one accepted input transfer.
        function void take_transfer(bit cmd, bit [BYTE_W-1:0] b, bit last);
            t_owed r;
            r = '0;
            if (cmd == CMD_TICK) begin
                r.kind = KIND_REPORT;
                for (int j = 0; j < NUM_COUNTS; j++) begin
                    r.totals[j] = counts[j][TOTAL_W-1:0];
                    counts[j]   = 0;
                end
                owed.push_back(r);
                return;
            end
            capture(b);
            if (!last) return;
            r.kind = KIND_FRAME;
            r.cls  = classify();
            if (r.cls != CLS_DROP) bump(r.cls);
            bump(CNT_ALL);
            clear_frame();
            owed.push_back(r);
        endfunction

        // Compare one accepted result with the oldest owed one.
        function void check_output(bit kind, bit [TDATA_OUT_W-1:0] data);
            t_owed exp_r;
            bit [TOTAL_W-1:0] got;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%h", $time, kind, data);
                faults++;
                return;
            end
            exp_r = owed.pop_front();
            if (kind != exp_r.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, kind);
                faults++;
            end
            if (data[CLASS_W-1:0] != exp_r.cls) begin
                $display("%0t: pkt_class expected %0d actual %0d",
                         $time, exp_r.cls, data[CLASS_W-1:0]);
                faults++;
            end
            for (int j = 0; j < NUM_COUNTS; j++) begin
                got = data[CLASS_W + j * TOTAL_W +: TOTAL_W];
                if (got != exp_r.totals[j]) begin
                    $display("%0t: total %0d expected %0d actual %0d",
                             $time, j, exp_r.totals[j], got);
                    faults++;
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [LINK_LEN_W-1:0]     i_cfg_wr_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [BYTE_W-1:0]         s_axis_tdata;   // frame_byte
    logic                      s_axis_tlast;   // last_byte
    logic                      s_axis_tuser;   // cmd
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // pkt_class, tcp_total, udp_total, icmp_total, other_total, all_total, zero pad
    logic [TDATA_OUT_W-1:0]    m_axis_tdata;
    logic                      m_axis_tuser;   // kind

    ipv4_tally        tally;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int unsigned      sent_items;
    int unsigned      quiet_cycles;
    bit [BYTE_W-1:0]  frame_buf [$];

    ipv4_protocol_counter_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Receiver backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tally.check_output(m_axis_tuser, m_axis_tdata);
        end
    end

    // Stop a run that has stopped moving.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one input and hold it until the transfer completes.
    task automatic push_transfer(input bit cmd, input bit [BYTE_W-1:0] b, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tally.take_transfer(cmd, b, last);
        sent_items++;
    endtask

    // Let every owed result arrive, then let the pipeline settle.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (tally.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_link_len(input bit [LINK_LEN_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tally.link_len = v;
    endtask

    // Build a frame: mostly well-formed headers with random content, some noise.
    function automatic void build_frame(int link);
        int roll;
        int ihl;
        int ver;
        int proto;
        int off;
        int need;
        int len;
        roll = $urandom_range(99);
        frame_buf.delete();
        if (roll < 15) begin
            len = (roll < 2) ? $urandom_range(256, 300) : $urandom_range(1, 40);
            repeat (len) frame_buf.push_back(8'($urandom_range(255)));
            return;
        end
        ihl = ($urandom_range(9) < 6) ? 5 : $urandom_range(15);
        ver = ($urandom_range(9) < 9) ? IP_VERSION_4 : $urandom_range(15);
        case ($urandom_range(3))
            0: proto = PROTO_TCP;
            1: proto = PROTO_UDP;
            2: proto = PROTO_ICMP;
            default: proto = $urandom_range(255);
        endcase
        off  = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
        need = (proto == PROTO_TCP) ? link + ihl * 4 + 13 : link + 10;
        len  = need + $urandom_range(6);
        if ($urandom_range(9) == 0) len = $urandom_range(1, need);
        repeat (len) frame_buf.push_back(8'($urandom_range(255)));
        if (link < len) frame_buf[link] = {ver[3:0], ihl[3:0]};
        if (link + 9 < len) frame_buf[link + 9] = proto[7:0];
        if (link + ihl * 4 + 12 < len)
            frame_buf[link + ihl * 4 + 12] = {off[3:0], 4'($urandom_range(15))};
    endfunction

    // Send the built frame with ticks scattered among its bytes.
    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++) begin
            if ($urandom_range(99) < TICK_PCT)
                push_transfer(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
            push_transfer(CMD_BYTE, frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    initial begin
        int unsigned target;
        int          link;
        tally         = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = CMD_BYTE;
        m_axis_tready = 1'b0;
        quiet_cycles  = 0;
        sent_items    = 0;
        tx_idle_pct   = 23;
        rx_idle_pct   = 67;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with no link header, so frames stay short.
        write_link_len(LINK_LEN_W'(0));
        // Report of cleared counters; the byte and last fields are ignored.
        push_transfer(CMD_TICK, 8'hFF, 1'b1);
        // A one-byte frame ends after its version and IHL byte, before the protocol field.
        push_transfer(CMD_BYTE, 8'h00, 1'b1);
        // UDP with the largest IP header length.
        for (int i = 0; i < 10; i++)
            push_transfer(CMD_BYTE, (i == 0) ? 8'h4F : (i == 9) ? 8'(PROTO_UDP) : 8'hFF,
                          i == 9);
        // IP header length too small, with a tick in the middle of the frame.
        for (int i = 0; i < 10; i++) begin
            if (i == 3) push_transfer(CMD_TICK, 8'h00, 1'b0);
            push_transfer(CMD_BYTE, (i == 0) ? 8'h44 : (i == 9) ? 8'(PROTO_ICMP) : 8'h00,
                          i == 9);
        end
        push_transfer(CMD_TICK, 8'h00, 1'b0);

        // Random phases; each ends in an unfinished frame that the next phase, if any, carries on.
        for (int p = 0; p < 6; p++) begin
            tx_idle_pct = (p < 2) ? 23 : (p < 4) ? 67 : 0;
            rx_idle_pct = (p < 2) ? 67 : (p < 4) ? 23 : 0;
            case (p)
                0: link = 0;
                1: link = 64;
                2: link = LINK_LEN_RESET;
                3: link = 51;
                4: link = $urandom_range(64);
                default: link = 3;
            endcase
            wait_quiet();
            write_link_len(link[LINK_LEN_W-1:0]);
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                build_frame(link);
                send_frame();
            end
            repeat ($urandom_range(1, 5))
                push_transfer(CMD_BYTE, 8'($urandom_range(255)), 1'b0);
        end

        wait_quiet();
        if (tally.faults == 0 && tally.owed.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
